// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam logic [1:0] OP_PUT     = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;
	localparam logic [1:0] OP_RECOLOR = 2'd3;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] DEFAULT_ATTR = 8'h0F;
	localparam int         TAB_STOP     = 4;

	typedef struct packed {
		logic [6:0] cell_col;
		logic [4:0] cell_row;
		logic [7:0] char_code;
		logic [1:0] opcode;
	} item_t;

	typedef struct packed {
		logic [7:0] cell_attr;
		logic [7:0] cell_char;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
	} result_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ_WAIT,
		ST_CLEAR,
		ST_RECOLOR,
		ST_SCROLL,
		ST_FILL,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/core/tcw_cell_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/tcw_seq.sv -----
// ----------------------------------------------------------------------------
// tcw_seq
// Operation sequencer: holds the cursor and walks the cell store for puts,
// reads, clears, recolors and scrolls.
// ----------------------------------------------------------------------------
module tcw_seq
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int AW      = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  item_t         item,
	input  logic [7:0]    text_attr,
	output logic          res_valid,
	input  logic          res_ready,
	output result_t       res,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [15:0]   wr_data,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  logic [15:0]   rd_data
);

	localparam int N  = ROWS * COLUMNS;
	localparam int NW = $clog2(N + 1);
	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLUMNS + 1);

	localparam logic [NW-1:0] N_C        = NW'(N);
	localparam logic [NW-1:0] LAST_N     = NW'(N - 1);
	localparam logic [NW-1:0] COLS_N     = NW'(COLUMNS);
	localparam logic [NW-1:0] COLS_P1    = NW'(COLUMNS + 1);
	localparam logic [NW-1:0] FILL_START = NW'((ROWS - 1) * COLUMNS);
	localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
	localparam logic [CW-1:0] COLS_C     = CW'(COLUMNS);
	localparam logic [CW-1:0] TAB_MASK   = CW'(TAB_STOP - 1);
	localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);

	state_t        state_q, state_d;
	logic [NW-1:0] cnt_q, cnt_d;
	logic [RW-1:0] line_q, line_d;
	logic [CW-1:0] col_q, col_d;
	logic [7:0]    rch_q, rch_d;
	logic [7:0]    rattr_q, rattr_d;
	item_t         item_q;

	logic [NW-1:0] cnt_inc;
	logic [NW-1:0] cnt_dec;
	logic [NW-1:0] scroll_dst;
	logic [CW-1:0] col_inc;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] cell_addr;
	logic          cell_in_range;
	logic [7:0]    col_ext;
	logic [15:0]   blank;

	assign cnt_inc    = cnt_q + NW'(1);
	assign cnt_dec    = cnt_q - NW'(1);
	assign scroll_dst = cnt_q - COLS_P1;
	assign col_inc    = col_q + CW'(1);
	assign cur_addr   = AW'(line_q) * COLS_A + AW'(col_q);
	assign cell_addr  = AW'(item_q.cell_row) * COLS_A + AW'(item_q.cell_col);
	assign cell_in_range = (6'(item_q.cell_row) < 6'(ROWS))
		&& (8'(item_q.cell_col) < 8'(COLUMNS));
	assign blank      = {text_attr, BLANK_CHAR};
	assign col_ext    = 8'(col_q);

	assign res.cursor_row = 5'(line_q);
	assign res.cursor_col = col_ext[6:0];
	assign res.cell_char  = rch_q;
	assign res.cell_attr  = rattr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			line_q  <= '0;
			col_q   <= '0;
			rch_q   <= '0;
			rattr_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			line_q  <= line_d;
			col_q   <= col_d;
			rch_q   <= rch_d;
			rattr_q <= rattr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		line_d     = line_q;
		col_d      = col_q;
		rch_d      = rch_q;
		rattr_d    = rattr_q;
		wr_en      = 1'b0;
		wr_addr    = cnt_q[AW-1:0];
		wr_data    = blank;
		rd_en      = 1'b0;
		rd_addr    = cnt_q[AW-1:0];
		item_ready = 1'b0;
		res_valid  = 1'b0;

		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = {DEFAULT_ATTR, BLANK_CHAR};
				cnt_d   = cnt_inc;
				if (cnt_q == LAST_N) begin
					cnt_d   = '0;
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
				end
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				rch_d   = '0;
				rattr_d = '0;
				unique case (item_q.opcode)
					OP_PUT: begin
						priority if (item_q.char_code == CH_NUL) begin
							state_d = ST_DONE;
						end else if (item_q.char_code == CH_LF) begin
							col_d = '0;
							if (line_q != LAST_ROW) begin
								line_d  = line_q + RW'(1);
								state_d = ST_DONE;
							end else begin
								cnt_d   = COLS_N;
								state_d = ST_SCROLL;
							end
						end else if (item_q.char_code == CH_CR) begin
							col_d   = '0;
							state_d = ST_DONE;
						end else if (item_q.char_code == CH_BS) begin
							if (col_q == '0) begin
								if (line_q == '0) begin
									state_d = ST_DONE;
								end else begin
									line_d  = line_q - RW'(1);
									col_d   = COLS_C - CW'(1);
									state_d = ST_WRITE;
								end
							end else begin
								col_d   = col_q - CW'(1);
								state_d = ST_WRITE;
							end
						end else if (col_q == COLS_C) begin
							col_d = '0;
							if (line_q != LAST_ROW) begin
								line_d  = line_q + RW'(1);
								state_d = ST_WRITE;
							end else begin
								cnt_d   = COLS_N;
								state_d = ST_SCROLL;
							end
						end else begin
							state_d = ST_WRITE;
						end
					end
					OP_READ: begin
						if (cell_in_range) begin
							rd_en   = 1'b1;
							rd_addr = cell_addr;
							state_d = ST_READ_WAIT;
						end else begin
							state_d = ST_DONE;
						end
					end
					OP_CLEAR: begin
						line_d  = '0;
						col_d   = '0;
						cnt_d   = '0;
						state_d = ST_CLEAR;
					end
					OP_RECOLOR: begin
						cnt_d   = '0;
						state_d = ST_RECOLOR;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_READ_WAIT: begin
				rch_d   = rd_data[7:0];
				rattr_d = rd_data[15:8];
				state_d = ST_DONE;
			end
			ST_SCROLL: begin
				rd_en   = (cnt_q != N_C);
				wr_en   = (cnt_q != COLS_N);
				wr_addr = scroll_dst[AW-1:0];
				wr_data = rd_data;
				cnt_d   = cnt_inc;
				if (cnt_q == N_C) begin
					cnt_d   = FILL_START;
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				wr_en = 1'b1;
				cnt_d = cnt_inc;
				if (cnt_q == LAST_N) begin
					cnt_d   = '0;
					state_d = (item_q.char_code == CH_LF) ? ST_DONE : ST_WRITE;
				end
			end
			ST_RECOLOR: begin
				rd_en   = (cnt_q != N_C);
				wr_en   = (cnt_q != '0);
				wr_addr = cnt_dec[AW-1:0];
				wr_data = {item_q.char_code, rd_data[7:0]};
				cnt_d   = cnt_inc;
				if (cnt_q == N_C) begin
					cnt_d   = '0;
					state_d = ST_DONE;
				end
			end
			ST_WRITE: begin
				wr_en   = 1'b1;
				wr_addr = cur_addr;
				if (item_q.char_code == CH_BS) begin
					state_d = ST_DONE;
				end else if (item_q.char_code == CH_TAB) begin
					col_d = col_inc;
					if (((col_inc & TAB_MASK) == '0) || (col_inc == COLS_C)) begin
						state_d = ST_DONE;
					end
				end else begin
					wr_data = {text_attr, item_q.char_code};
					col_d   = col_inc;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/text_console_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console engine with a screen of character and attribute cells and a
// cursor, driven by one opcode per input beat.
//
//   Channel  Direction  Contents
//   s_*      in         tuser: opcode; tdata: char_code, cell_row, cell_col
//   m_*      out        tdata: cursor_row, cursor_col, cell_char, cell_attr
//   cfg_*    in         text attribute register
//
// Clear, recolor, and a newline or wrap on the last row each walk the screen
// cell by cell through the single read and write ports of the cell store; a
// tab writes blanks up to the next tab stop or the end of the line.
// After reset a clearing pass over every cell runs before the first
// beat is taken. A result waits in the output register while the next beat
// is accepted.
// ----------------------------------------------------------------------------
module text_console_writer_core
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // opcode
	input  logic [23:0] s_tdata,   // char_code, cell_row, cell_col, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cursor_row, cursor_col, cell_char, cell_attr, zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int N  = ROWS * COLUMNS;
	localparam int AW = $clog2(N);

	logic [7:0]    attr_q;
	logic          m_tvalid_q;
	result_t       m_res_q;
	item_t         item;
	result_t       res;
	logic          res_valid;
	logic          res_ready;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [15:0]   rd_data;

	assign item.opcode    = s_tuser;
	assign item.char_code = s_tdata[7:0];
	assign item.cell_row  = s_tdata[12:8];
	assign item.cell_col  = s_tdata[19:13];

	assign cfg_ready = 1'b1;
	assign res_ready = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {4'b0000, m_res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= DEFAULT_ATTR;
		end else if (cfg_valid) begin
			attr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	tcw_seq #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.AW      (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.item       (item),
		.text_attr  (attr_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	tcw_cell_ram #(
		.DEPTH (N),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
